// File: rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the exponential saturation curve pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int ZZ_W       = 37;   // biased exponent argument, unsigned Q5.32
    localparam int Q_BITS     = 6;    // quotient bits of the ln2 reduction
    localparam int DIV_STEPS  = 2;    // quotient bits resolved per stage
    localparam int DIV_STAGES = Q_BITS / DIV_STEPS;
    localparam int MUL3_SHIFT = 29;

    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [63:0] Z_MAX     = 64'h0000_0007_0000_0000;
    localparam logic [63:0] Z_MIN_MAG = 64'h0000_0010_0000_0000;
    localparam logic [37:0] ZZ_BIAS   = 38'd71449067328;   // 24 * ln2
    localparam logic [6:0]  Q_BIAS    = 7'd24;
    localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
    localparam logic [28:0] MUL3      = 29'd178956971;      // (2^29 + 1) / 3
    localparam logic [6:0]  E_SHIFT0  = 7'd10;
    localparam logic [63:0] RND_HALF  = 64'd524288;         // 2^19

    // item data that rides alongside the exponent math
    typedef struct packed {
        logic               last;
        logic               pre;    // position before onset
        logic [31:0]        base;
        logic signed [32:0] diff;   // plateau - baseline
    } esc_side_t;

endpackage

// File: rtl/esc_arg.sv
// ----------------------------------------------------------------------------
// esc_arg
// Exponent argument: offset, rate product, clamp and bias (three stages).
// ----------------------------------------------------------------------------
module esc_arg
    import esc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  logic [31:0]       position,
    input  logic [31:0]       onset,
    input  logic [31:0]       baseline,
    input  logic [31:0]       plateau,
    input  logic [31:0]       rate,
    input  logic              last_in,
    output logic              out_valid,
    output esc_side_t         out_side,
    output logic [ZZ_W-1:0]   zz
);

    logic        v1_reg, v2_reg, v3_reg;
    esc_side_t   side1_reg, side2_reg, side3_reg;
    logic        kneg1_reg, kneg2_reg;
    logic [31:0] kmag1_reg, dmag1_reg;
    logic [63:0] pmag2_reg;
    logic [ZZ_W-1:0] zz3_reg;

    logic [32:0] d;
    logic [31:0] kmag;
    esc_side_t   side_next;
    logic [63:0] zmag;
    logic [37:0] zs;
    logic [37:0] zsum;
    logic [ZZ_W-1:0] zz_next;

    always_comb
    begin
        d                = {position[31], position} - {onset[31], onset};
        kmag             = rate[31] ? (~rate + 32'd1) : rate;
        side_next.last   = last_in;
        side_next.pre    = d[32];
        side_next.base   = baseline;
        side_next.diff   = $signed({plateau[31], plateau}) - $signed({baseline[31], baseline});
    end

    always_comb
    begin
        if (kneg2_reg)
        begin
            zmag = (pmag2_reg > Z_MAX) ? Z_MAX : pmag2_reg;
            zs   = zmag[37:0];
        end
        else
        begin
            zmag = (pmag2_reg > Z_MIN_MAG) ? Z_MIN_MAG : pmag2_reg;
            zs   = ~zmag[37:0] + 38'd1;
        end
        zsum    = zs + ZZ_BIAS;
        zz_next = zsum[ZZ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side1_reg <= side_next;
            kneg1_reg <= rate[31];
            kmag1_reg <= kmag;
            dmag1_reg <= d[31:0];
            side2_reg <= side1_reg;
            kneg2_reg <= kneg1_reg;
            pmag2_reg <= kmag1_reg * dmag1_reg;
            side3_reg <= side2_reg;
            zz3_reg   <= zz_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_side  = side3_reg;
    assign zz        = zz3_reg;

endmodule

// File: rtl/esc_reduce.sv
// ----------------------------------------------------------------------------
// esc_reduce
// Range reduction by ln2: restoring division, two quotient bits per stage.
// ----------------------------------------------------------------------------
module esc_reduce
    import esc_pkg::*;
#(
    parameter int EXP_TABLE_BITS = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       in_valid,
    input  esc_side_t                  in_side,
    input  logic [ZZ_W-1:0]            zz,
    output logic                       out_valid,
    output esc_side_t                  out_side,
    output logic [29-EXP_TABLE_BITS:0] s,
    output logic signed [6:0]          n
);

    logic [ZZ_W-1:0]   rem_in   [DIV_STAGES+1];
    logic [Q_BITS-1:0] q_in     [DIV_STAGES+1];
    logic              v_in     [DIV_STAGES+1];
    esc_side_t         side_in  [DIV_STAGES+1];

    logic [ZZ_W-1:0]   rem_reg  [DIV_STAGES];
    logic [Q_BITS-1:0] q_reg    [DIV_STAGES];
    logic              v_reg    [DIV_STAGES];
    esc_side_t         side_reg [DIV_STAGES];

    assign rem_in[0]  = zz;
    assign q_in[0]    = '0;
    assign v_in[0]    = in_valid;
    assign side_in[0] = in_side;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        logic [ZZ_W-1:0]   rem_next;
        logic [Q_BITS-1:0] q_next;
        logic [ZZ_W-1:0]   dvs;

        always_comb
        begin
            rem_next = rem_in[g];
            q_next   = q_in[g];
            dvs      = '0;
            for (int t = 0; t < DIV_STEPS; t++)
            begin
                dvs = {{(ZZ_W-32){1'b0}}, LN2_Q32} << (Q_BITS - 1 - DIV_STEPS * g - t);
                if (rem_next >= dvs)
                begin
                    rem_next = rem_next - dvs;
                    q_next[Q_BITS - 1 - DIV_STEPS * g - t] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g] <= 1'b0;
            else if (advance)
                v_reg[g] <= v_in[g];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[g]  <= rem_next;
                q_reg[g]    <= q_next;
                side_reg[g] <= side_in[g];
            end
        end

        assign rem_in[g+1]  = rem_reg[g];
        assign q_in[g+1]    = q_reg[g];
        assign v_in[g+1]    = v_reg[g];
        assign side_in[g+1] = side_reg[g];
    end

    // remainder is below ln2, so it fits the low 32 bits
    assign s         = rem_in[DIV_STAGES][31:2+EXP_TABLE_BITS];
    assign n         = $signed({1'b0, q_in[DIV_STAGES]}) - $signed(Q_BIAS);
    assign out_valid = v_in[DIV_STAGES];
    assign out_side  = side_in[DIV_STAGES];

endmodule

// File: rtl/esc_exp.sv
// ----------------------------------------------------------------------------
// esc_exp
// Fourth-order series on the reduced argument, repeated squaring, and the
// power-of-two scale to a Q.20 exponential.
// ----------------------------------------------------------------------------
module esc_exp
    import esc_pkg::*;
#(
    parameter int EXP_TABLE_BITS = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       in_valid,
    input  esc_side_t                  in_side,
    input  logic [29-EXP_TABLE_BITS:0] s,
    input  logic signed [6:0]          n,
    output logic                       out_valid,
    output esc_side_t                  out_side,
    output logic [31:0]                e
);

    localparam int W_S   = 30 - EXP_TABLE_BITS;
    localparam int W_V   = W_S + 2;
    localparam int W_T   = W_V + MUL3_SHIFT;
    localparam int DEPTH = EXP_TABLE_BITS + 6;

    logic                v_reg    [DEPTH];
    esc_side_t           side_reg [DEPTH];
    logic signed [6:0]   n_reg    [DEPTH];
    logic [W_S-1:0]      sl_reg   [4];

    logic [31:0]         a1_reg;
    logic [W_S+31:0]     p1_reg;
    logic [W_T-1:0]      t_reg;
    logic [W_S+31:0]     p2_reg;
    logic [W_S+31:0]     p3_reg;
    logic [63:0]         sq_reg   [EXP_TABLE_BITS];
    logic [31:0]         e_reg;

    logic [31:0] a2, a3, a4, a_fin;
    logic [6:0]  shw;

    always_comb
    begin
        a2    = ONE_Q30 + 32'(t_reg >> MUL3_SHIFT);
        a3    = ONE_Q30 + 32'(p2_reg >> 31);   // >>30 then /2
        a4    = ONE_Q30 + 32'(p3_reg >> 30);
        a_fin = sq_reg[EXP_TABLE_BITS-1][61:30];
        shw   = E_SHIFT0 - n_reg[DEPTH-2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                v_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= in_side;
            n_reg[0]    <= n;
            for (int i = 1; i < DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
                n_reg[i]    <= n_reg[i-1];
            end
            sl_reg[0] <= s;
            for (int i = 1; i < 4; i++)
                sl_reg[i] <= sl_reg[i-1];

            a1_reg    <= ONE_Q30 + 32'(s >> 2);
            p1_reg    <= sl_reg[0] * a1_reg;
            t_reg     <= p1_reg[W_S+31:30] * MUL3;
            p2_reg    <= sl_reg[2] * a2;
            p3_reg    <= sl_reg[3] * a3;
            sq_reg[0] <= a4 * a4;
            for (int i = 1; i < EXP_TABLE_BITS; i++)
                sq_reg[i] <= sq_reg[i-1][61:30] * sq_reg[i-1][61:30];
            e_reg     <= a_fin >> shw[5:0];
        end
    end

    assign out_valid = v_reg[DEPTH-1];
    assign out_side  = side_reg[DEPTH-1];
    assign e         = e_reg;

endmodule

// File: rtl/esc_blend.sv
// ----------------------------------------------------------------------------
// esc_blend
// Scales plateau - baseline by 1 - exp, rounds, adds baseline and saturates;
// before onset it passes baseline. The last stage is the output register.
// ----------------------------------------------------------------------------
module esc_blend
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        in_valid,
    input  esc_side_t   in_side,
    input  logic [31:0] e,
    output logic        out_valid,
    output logic [31:0] curve_value,
    output logic        last_out
);

    logic        v0_reg, v1_reg, v2_reg;
    esc_side_t   side0_reg, side1_reg;
    logic        neg0_reg, neg1_reg;
    logic [31:0] gmag0_reg, dmag0_reg;
    logic [63:0] prod1_reg;
    logic [31:0] val2_reg;
    logic        last2_reg;

    logic [32:0] g;
    logic [32:0] ndiff;
    logic [31:0] gmag, dmag;
    logic [63:0] rnd;
    logic [45:0] bext, mext, sum;
    logic [31:0] val_next;

    always_comb
    begin
        g     = 33'h0010_0000 - {1'b0, e};
        gmag  = g[32] ? 32'(~g + 33'd1) : g[31:0];
        ndiff = ~in_side.diff + 33'd1;
        dmag  = in_side.diff[32] ? ndiff[31:0] : in_side.diff[31:0];
    end

    always_comb
    begin
        rnd  = prod1_reg + RND_HALF;
        bext = {{14{side1_reg.base[31]}}, side1_reg.base};
        mext = {2'b00, rnd[63:20]};
        sum  = neg1_reg ? (bext - mext) : (bext + mext);
        if (side1_reg.pre)
            val_next = side1_reg.base;
        else if (!sum[45] && (|sum[44:31]))
            val_next = 32'h7FFF_FFFF;
        else if (sum[45] && !(&sum[44:31]))
            val_next = 32'h8000_0000;
        else
            val_next = sum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side0_reg <= in_side;
            neg0_reg  <= g[32] ^ in_side.diff[32];
            gmag0_reg <= gmag;
            dmag0_reg <= dmag;
            side1_reg <= side0_reg;
            neg1_reg  <= neg0_reg;
            prod1_reg <= dmag0_reg * gmag0_reg;
            val2_reg  <= val_next;
            last2_reg <= side1_reg.last;
        end
    end

    assign out_valid   = v2_reg;
    assign curve_value = val2_reg;
    assign last_out    = last2_reg;

endmodule

// File: rtl/exponential_saturation_curve.sv
// ----------------------------------------------------------------------------
// exponential_saturation_curve
// Streams samples of baseline + (plateau - baseline) * (1 - exp(-rate * dx)).
// ----------------------------------------------------------------------------
// Input channel s_axis: one item per grid sample, carrying position, onset,
// baseline, plateau and rate (signed Q16.16) in tdata and the end-of-curve
// mark in tlast. Output channel m_axis: the saturated curve value in tdata
// and the copied mark in tlast.
// The pipeline holds three stages of argument setup, three of ln2
// reduction, EXP_TABLE_BITS + 6 of series, squaring and scaling, and three
// of blend into the output register.
// One item per cycle unless the receiver stalls; at most one multiplier per stage.
// Reset clears only the valid bits, so the pipeline comes up empty.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and tready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module exponential_saturation_curve
    import esc_pkg::*;
#(
    parameter int EXP_TABLE_BITS = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,  // position, onset, baseline, plateau, rate
    input  logic         s_axis_tlast,  // last_in
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // curve_value
    output logic         m_axis_tlast   // last_out
);

    logic                       advance;
    logic                       arg_valid, red_valid, exp_valid;
    esc_side_t                  arg_side, red_side, exp_side;
    logic [ZZ_W-1:0]            zz;
    logic [29-EXP_TABLE_BITS:0] s;
    logic signed [6:0]          n;
    logic [31:0]                e;

    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    esc_arg u_arg (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s_axis_tvalid),
        .position  (s_axis_tdata[31:0]),
        .onset     (s_axis_tdata[63:32]),
        .baseline  (s_axis_tdata[95:64]),
        .plateau   (s_axis_tdata[127:96]),
        .rate      (s_axis_tdata[159:128]),
        .last_in   (s_axis_tlast),
        .out_valid (arg_valid),
        .out_side  (arg_side),
        .zz        (zz)
    );

    esc_reduce #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (arg_valid),
        .in_side   (arg_side),
        .zz        (zz),
        .out_valid (red_valid),
        .out_side  (red_side),
        .s         (s),
        .n         (n)
    );

    esc_exp #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (red_valid),
        .in_side   (red_side),
        .s         (s),
        .n         (n),
        .out_valid (exp_valid),
        .out_side  (exp_side),
        .e         (e)
    );

    esc_blend u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (exp_valid),
        .in_side     (exp_side),
        .e           (e),
        .out_valid   (m_axis_tvalid),
        .curve_value (m_axis_tdata),
        .last_out    (m_axis_tlast)
    );

endmodule
